// ===== sv/c3f_pkg.sv =====
// shared types, constants and kernel tables for the 3x3 filter core
package c3f_pkg;

    localparam int MAX_WIDTH_DEF = 512;
    localparam int MAX_HEIGHT    = 512;
    localparam int PIX_W         = 8;
    localparam int DIM_W         = 10;
    localparam int ROW_W         = 10;
    localparam int CFG_IDX_W     = 2;
    localparam int SUM_W         = 14;
    localparam int KCOEF_W       = 4;

    localparam int BLUR_DIV      = 25;
    localparam int BLUR_BIAS     = BLUR_DIV / 2;
    localparam int BLUR_SHIFT    = 17;
    localparam int BLUR_RECIP    = ((1 << BLUR_SHIFT) + BLUR_DIV - 1) / BLUR_DIV;

    localparam logic KSEL_SHARPEN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_SELECT = 2'd0,
        REG_IMAGE_WIDTH   = 2'd1,
        REG_IMAGE_HEIGHT  = 2'd2
    } cfg_reg_t;

    localparam logic signed [KCOEF_W-1:0] SHARPEN_K [9] = '{
        -4'sd1, 4'sd0, -4'sd1,
         4'sd0, 4'sd6,  4'sd0,
        -4'sd1, 4'sd0, -4'sd1
    };

    localparam logic signed [KCOEF_W-1:0] BLUR_K [9] = '{
        4'sd1, 4'sd0, 4'sd4,
        4'sd2, 4'sd5, 4'sd2,
        4'sd1, 4'sd0, 4'sd4
    };

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last_of_frame;
    } out_item_t;

    typedef struct packed {
        logic emit;
        logic last;
        logic sharpen;
        logic mask_top;
        logic mask_bottom;
        logic mask_left;
        logic mask_right;
    } flags_t;

    typedef logic [8:0][PIX_W-1:0] win_t;

endpackage

// ===== sv/c3f_line_ram.sv =====
// two-row line memory with registered read and a clearing sweep after reset
module c3f_line_ram #(
    parameter int MAX_WIDTH = c3f_pkg::MAX_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
    output logic [2*c3f_pkg::PIX_W-1:0]   rd_data,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
    input  logic [2*c3f_pkg::PIX_W-1:0]   wr_data,
    output logic                          clearing
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int DW = 2 * c3f_pkg::PIX_W;

    logic [DW-1:0] mem [MAX_WIDTH];
    logic [DW-1:0] rd_data_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    logic          port_we;
    logic [AW-1:0] port_addr;
    logic [DW-1:0] port_data;

    always_comb begin
        port_we   = clr_busy_reg || wr_en;
        port_addr = clr_busy_reg ? clr_addr_reg : wr_addr;
        port_data = clr_busy_reg ? '0 : wr_data;
    end

    always_ff @(posedge aclk) begin
        if (port_we) begin
            mem[port_addr] <= port_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == AW'(MAX_WIDTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_busy_reg;

endmodule

// ===== sv/c3f_ctrl.sv =====
// configuration registers, raster position counters and per-pixel border flags
module c3f_ctrl #(
    parameter int MAX_WIDTH = c3f_pkg::MAX_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [c3f_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [c3f_pkg::DIM_W-1:0]        cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  c3f_pkg::in_item_t                s_data,
    input  logic                             clearing,
    input  logic                             b_ready,
    output logic                             acc,
    output logic [$clog2(MAX_WIDTH)-1:0]     acc_col,
    output logic [c3f_pkg::PIX_W-1:0]        acc_sample,
    output c3f_pkg::flags_t                  acc_flags
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int MW_W  = $clog2(MAX_WIDTH + 1);
    localparam int WW    = ((MW_W > c3f_pkg::DIM_W) ? MW_W : c3f_pkg::DIM_W) + 1;
    localparam int HW    = c3f_pkg::DIM_W + 1;

    logic                      kernel_reg;
    logic [c3f_pkg::DIM_W-1:0] width_reg;
    logic [c3f_pkg::DIM_W-1:0] height_reg;
    logic [COL_W-1:0]          col_reg, col_next;
    logic [c3f_pkg::ROW_W-1:0] row_reg, row_next;

    logic [WW-1:0] eff_w, col_w, ocol, col_inc;
    logic [HW-1:0] eff_h, row_h, orow, row_new;
    logic          col_nz, emit, last, wrap;

    always_comb begin
        if (width_reg == '0) begin
            eff_w = WW'(1);
        end else if (WW'(width_reg) > WW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(width_reg);
        end
        if (height_reg == '0) begin
            eff_h = HW'(1);
        end else if (HW'(height_reg) > HW'(c3f_pkg::MAX_HEIGHT)) begin
            eff_h = HW'(c3f_pkg::MAX_HEIGHT);
        end else begin
            eff_h = HW'(height_reg);
        end

        col_w  = WW'(col_reg);
        row_h  = HW'(row_reg);
        col_nz = (col_reg != '0);
        emit   = (row_h >= HW'(2)) || ((row_h == HW'(1)) && col_nz);
        // output pixel lags one row and one column behind the newest sample
        ocol   = col_nz ? col_w - WW'(1) : eff_w - WW'(1);
        orow   = col_nz ? row_h - HW'(1) : row_h - HW'(2);
        last   = emit && (orow == eff_h - HW'(1)) && (ocol == eff_w - WW'(1));

        acc_flags.emit        = emit;
        acc_flags.last        = last;
        acc_flags.sharpen     = (kernel_reg == c3f_pkg::KSEL_SHARPEN);
        acc_flags.mask_top    = (orow == '0);
        acc_flags.mask_bottom = (orow >= eff_h - HW'(1));
        acc_flags.mask_left   = (ocol == '0);
        acc_flags.mask_right  = (ocol >= eff_w - WW'(1));

        s_ready    = b_ready && !clearing;
        acc        = s_valid && s_ready;
        acc_col    = col_reg;
        acc_sample = s_data.action ? '0 : s_data.pixel_in;

        col_inc = col_w + WW'(1);
        wrap    = (col_inc >= eff_w);
        row_new = wrap ? row_h + HW'(1) : row_h;
        col_next = col_reg;
        row_next = row_reg;
        if (acc) begin
            if (last || (row_new > eff_h + HW'(1))) begin
                col_next = '0;
                row_next = '0;
            end else begin
                col_next = wrap ? '0 : COL_W'(col_inc);
                row_next = c3f_pkg::ROW_W'(row_new);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_reg <= 1'b1;
            width_reg  <= c3f_pkg::DIM_W'(512);
            height_reg <= c3f_pkg::DIM_W'(512);
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    c3f_pkg::REG_KERNEL_SELECT: begin
                        kernel_reg <= cfg_data[0];
                    end
                    c3f_pkg::REG_IMAGE_WIDTH: begin
                        width_reg <= cfg_data;
                    end
                    c3f_pkg::REG_IMAGE_HEIGHT: begin
                        height_reg <= cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== sv/c3f_window.sv =====
// line memory read-modify-write stage with forwarding and the 3x3 window shift
module c3f_window #(
    parameter int MAX_WIDTH = c3f_pkg::MAX_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            acc,
    input  logic [$clog2(MAX_WIDTH)-1:0]    acc_col,
    input  logic [c3f_pkg::PIX_W-1:0]       acc_sample,
    input  c3f_pkg::flags_t                 acc_flags,
    input  logic [2*c3f_pkg::PIX_W-1:0]     rd_data,
    output logic                            wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
    output logic [2*c3f_pkg::PIX_W-1:0]     wr_data,
    output logic                            b_ready,
    input  logic                            c_ready,
    output logic                            c_load,
    output c3f_pkg::flags_t                 c_flags,
    output c3f_pkg::win_t                   win
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int PW    = c3f_pkg::PIX_W;

    logic                   b_valid_reg;
    logic [COL_W-1:0]       b_col_reg;
    logic [PW-1:0]          b_sample_reg;
    c3f_pkg::flags_t        b_flags_reg;
    logic                   fwd_reg;
    logic [2*PW-1:0]        last_wr_reg;
    c3f_pkg::win_t          win_reg;

    logic                   b_adv;
    logic [2*PW-1:0]        line;
    logic [PW-1:0]          up1, up2;

    always_comb begin
        b_ready = !b_valid_reg || c_ready;
        b_adv   = b_valid_reg && c_ready;
        // back-to-back transactions on the same column miss the write in flight
        line    = fwd_reg ? last_wr_reg : rd_data;
        up1     = line[PW-1:0];
        up2     = line[2*PW-1:PW];
        wr_en   = b_adv;
        wr_addr = b_col_reg;
        wr_data = {up1, b_sample_reg};
        c_load  = b_adv && b_flags_reg.emit;
        c_flags = b_flags_reg;
        win     = win_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            win_reg     <= '0;
        end else begin
            if (acc) begin
                b_valid_reg <= 1'b1;
                fwd_reg     <= b_valid_reg && (b_col_reg == acc_col);
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end
            if (b_adv) begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= up2;
                win_reg[3] <= win_reg[4];
                win_reg[4] <= win_reg[5];
                win_reg[5] <= up1;
                win_reg[6] <= win_reg[7];
                win_reg[7] <= win_reg[8];
                win_reg[8] <= b_sample_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            b_col_reg    <= acc_col;
            b_sample_reg <= acc_sample;
            b_flags_reg  <= acc_flags;
        end
        if (b_adv) begin
            last_wr_reg <= wr_data;
        end
    end

endmodule

// ===== sv/c3f_arith.sv =====
// masked kernel sum, blur division by reciprocal, clamp and output register
module c3f_arith (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  c_load,
    input  c3f_pkg::flags_t       c_flags,
    input  c3f_pkg::win_t         win,
    output logic                  c_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output c3f_pkg::out_item_t    m_data
);

    localparam int SW = c3f_pkg::SUM_W;
    localparam int XW = SW - 1;
    localparam int PW = c3f_pkg::PIX_W;

    logic                 c_valid_reg;
    c3f_pkg::flags_t      c_flags_reg;
    logic                 d_valid_reg;
    logic signed [SW-1:0] d_sum_reg;
    logic                 d_sharpen_reg;
    logic                 d_last_reg;
    logic                 m_valid_reg;
    c3f_pkg::out_item_t   m_data_reg;

    logic                 out_ready, d_ready;
    logic [2:0]           row_keep, col_keep;
    logic signed [SW-1:0] sum, coef_x, pix_x;
    logic signed [SW-1:0] biased;
    logic [XW-1:0]        blur_x;
    logic [2*XW-1:0]      blur_prod;
    logic [PW:0]          blur_q;
    logic [PW-1:0]        value;

    always_comb begin
        out_ready = !m_valid_reg || m_ready;
        d_ready   = !d_valid_reg || out_ready;
        c_ready   = !c_valid_reg || d_ready;

        row_keep = {!c_flags_reg.mask_bottom, 1'b1, !c_flags_reg.mask_top};
        col_keep = {!c_flags_reg.mask_right, 1'b1, !c_flags_reg.mask_left};
        sum      = '0;
        for (int k = 0; k < 3; k++) begin
            for (int l = 0; l < 3; l++) begin
                coef_x = c_flags_reg.sharpen ? SW'(c3f_pkg::SHARPEN_K[k*3+l])
                                             : SW'(c3f_pkg::BLUR_K[k*3+l]);
                pix_x  = SW'(win[k*3+l]);
                if (row_keep[k] && col_keep[l]) begin
                    sum = sum + coef_x * pix_x;
                end
            end
        end

        // divide by 25 through a scaled reciprocal, exact over the blur range
        biased    = d_sum_reg + SW'(c3f_pkg::BLUR_BIAS);
        blur_x    = biased[XW-1:0];
        blur_prod = (2*XW)'(blur_x) * (2*XW)'(c3f_pkg::BLUR_RECIP);
        blur_q    = blur_prod[c3f_pkg::BLUR_SHIFT +: PW+1];

        if (d_sharpen_reg) begin
            if (d_sum_reg < 0) begin
                value = '0;
            end else if (d_sum_reg > SW'(255)) begin
                value = '1;
            end else begin
                value = d_sum_reg[PW-1:0];
            end
        end else begin
            value = blur_q[PW] ? '1 : blur_q[PW-1:0];
        end

        m_valid = m_valid_reg;
        m_data  = m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (c_load) begin
                c_valid_reg <= 1'b1;
            end else if (c_valid_reg && d_ready) begin
                c_valid_reg <= 1'b0;
            end
            if (c_valid_reg && d_ready) begin
                d_valid_reg <= 1'b1;
            end else if (d_valid_reg && out_ready) begin
                d_valid_reg <= 1'b0;
            end
            if (d_valid_reg && out_ready) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c_load) begin
            c_flags_reg <= c_flags;
        end
        if (c_valid_reg && d_ready) begin
            d_sum_reg     <= sum;
            d_sharpen_reg <= c_flags_reg.sharpen;
            d_last_reg    <= c_flags_reg.last;
        end
        if (d_valid_reg && out_ready) begin
            m_data_reg.pixel_out     <= value;
            m_data_reg.last_of_frame <= d_last_reg;
        end
    end

endmodule

// ===== sv/conv3x3_zero_padded_filter_core.sv =====
// top level of the 3x3 zero-padded image filter core
//
// Takes 8-bit grey pixels in raster order, one per clock while s_ready is
// high, and returns the 3x3 filtered image of the same size (sharpen, or
// weighted blur divided by 25), with samples outside the frame taken as zero
// and results clamped to 0..255. The sustained rate is one pixel per clock,
// set by the line memory, which does one read and one write per pixel. A
// result passes the B, C, D and output registers after the transaction that
// completes its neighborhood; the first result of a frame follows input
// width+1, so a frame is drained by sending width+1 flush transactions after
// its last pixel. After reset the line memory clears all MAX_WIDTH entries,
// during which s_ready stays low; register writes are taken at any time but
// should only be issued while the core is idle.
module conv3x3_zero_padded_filter_core #(
    parameter int MAX_WIDTH = c3f_pkg::MAX_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [c3f_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [c3f_pkg::DIM_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  c3f_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output c3f_pkg::out_item_t            m_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int DW    = 2 * c3f_pkg::PIX_W;

    logic                     clearing, b_ready, c_ready, c_load;
    logic                     acc;
    logic [COL_W-1:0]         acc_col;
    logic [c3f_pkg::PIX_W-1:0] acc_sample;
    c3f_pkg::flags_t          acc_flags, c_flags;
    logic [DW-1:0]            rd_data, wr_data;
    logic                     wr_en;
    logic [COL_W-1:0]         wr_addr;
    c3f_pkg::win_t            win;

    c3f_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .clearing   (clearing),
        .b_ready    (b_ready),
        .acc        (acc),
        .acc_col    (acc_col),
        .acc_sample (acc_sample),
        .acc_flags  (acc_flags)
    );

    c3f_line_ram #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (acc),
        .rd_addr  (acc_col),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .clearing (clearing)
    );

    c3f_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .acc        (acc),
        .acc_col    (acc_col),
        .acc_sample (acc_sample),
        .acc_flags  (acc_flags),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .b_ready    (b_ready),
        .c_ready    (c_ready),
        .c_load     (c_load),
        .c_flags    (c_flags),
        .win        (win)
    );

    c3f_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .c_load  (c_load),
        .c_flags (c_flags),
        .win     (win),
        .c_ready (c_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== test/c3f_result_checker.sv =====
`timescale 1ns / 1ps
// result checker for the 3x3 filter core: tracks registers, predicts each filtered pixel, compares
module c3f_result_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [c3f_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [c3f_pkg::DIM_W-1:0]     cfg_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  c3f_pkg::in_item_t             s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  c3f_pkg::out_item_t            m_data,
    output int                            fail_count,
    output int                            pending,
    output logic                          frame_start
);

    import c3f_pkg::*;

    localparam int LINE_LEN  = MAX_WIDTH_DEF;
    localparam int BLUR_NORM = 25;
    localparam int SHARPEN_TAPS [9] = '{-1, 0, -1, 0, 6, 0, -1, 0, -1};
    localparam int BLUR_TAPS [9]    = '{1, 0, 4, 2, 5, 2, 1, 0, 4};

    // row one behind in the low half, row two behind in the high half
    logic [PIX_W-1:0] line_mem [0:2*LINE_LEN-1];
    logic [PIX_W-1:0] win [0:2][0:2];
    logic [9:0]       col_pos;
    logic [9:0]       row_pos;
    logic             kernel_sel;
    logic [DIM_W-1:0] cfg_width;
    logic [DIM_W-1:0] cfg_height;
    out_item_t        pending_pixels [$];
    int               mismatches;

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    task automatic clear_state();
        int i;
        int k;
        int l;
        for (i = 0; i < 2 * LINE_LEN; i++) line_mem[i] = '0;
        for (k = 0; k < 3; k++)
            for (l = 0; l < 3; l++) win[k][l] = '0;
        col_pos    = '0;
        row_pos    = '0;
        kernel_sel = KSEL_SHARPEN;
        cfg_width  = 10'd512;
        cfg_height = 10'd512;
        pending_pixels.delete();
        mismatches = 0;
    endtask

    // one accepted transaction: shift the neighborhood, maybe produce one filtered pixel
    task automatic filter_step(input in_item_t it);
        int unsigned      w;
        int unsigned      h;
        int unsigned      col;
        int unsigned      row;
        int unsigned      addr;
        int unsigned      orow;
        int unsigned      ocol;
        logic [PIX_W-1:0] smp;
        logic [PIX_W-1:0] up1;
        logic [PIX_W-1:0] up2;
        int               acc;
        int unsigned      val;
        bit               sharp;
        int               k;
        int               l;
        out_item_t        res;
        w    = clamp_dim(cfg_width, LINE_LEN);
        h    = clamp_dim(cfg_height, MAX_HEIGHT);
        col  = col_pos;
        row  = row_pos;
        smp  = it.action ? '0 : it.pixel_in;
        addr = col % LINE_LEN;
        up1  = line_mem[addr];
        up2  = line_mem[LINE_LEN + addr];
        line_mem[LINE_LEN + addr] = up1;
        line_mem[addr]            = smp;
        for (k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = up2;
        win[1][2] = up1;
        win[2][2] = smp;

        if (row >= 2 || (row == 1 && col >= 1)) begin
            if (col >= 1) begin
                ocol = col - 1;
                orow = row - 1;
            end else begin
                ocol = w - 1;
                orow = row - 2;
            end
            sharp = (kernel_sel == KSEL_SHARPEN);
            acc   = 0;
            for (k = 0; k < 3; k++) begin
                for (l = 0; l < 3; l++) begin
                    // zero padding outside the frame
                    if (k == 0 && orow == 0) continue;
                    if (k == 2 && orow >= h - 1) continue;
                    if (l == 0 && ocol == 0) continue;
                    if (l == 2 && ocol >= w - 1) continue;
                    acc += (sharp ? SHARPEN_TAPS[k*3+l] : BLUR_TAPS[k*3+l]) * int'(win[k][l]);
                end
            end
            if (sharp) begin
                val = (acc < 0) ? 0 : (acc > 255) ? 255 : acc;
            end else begin
                val = (acc + BLUR_NORM / 2) / BLUR_NORM;
                if (val > 255) val = 255;
            end
            res.pixel_out     = val[PIX_W-1:0];
            res.last_of_frame = (orow == h - 1) && (ocol == w - 1);
            pending_pixels.push_back(res);
            if (res.last_of_frame) begin
                col_pos = '0;
                row_pos = '0;
                return;
            end
        end

        col = col + 1;
        if (col >= w) begin
            col = 0;
            row = row + 1;
        end
        // height shrunk under a running frame
        if (row > h + 1) begin
            col = 0;
            row = 0;
        end
        col_pos = col;
        row_pos = row;
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            clear_state();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: pixel %0d last %0d",
                                 m_data.pixel_out, m_data.last_of_frame);
                end else begin
                    want = pending_pixels.pop_front();
                    if (m_data.pixel_out !== want.pixel_out ||
                        m_data.last_of_frame !== want.last_of_frame) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected pixel %0d last %0d, got pixel %0d last %0d",
                                     want.pixel_out, want.last_of_frame,
                                     m_data.pixel_out, m_data.last_of_frame);
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_KERNEL_SELECT: kernel_sel = cfg_data[0];
                    REG_IMAGE_WIDTH:   cfg_width  = cfg_data;
                    REG_IMAGE_HEIGHT:  cfg_height = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) filter_step(s_data);
        end
        fail_count  <= mismatches;
        pending     <= pending_pixels.size();
        frame_start <= (col_pos == 0) && (row_pos == 0);
    end

endmodule

// ===== test/conv3x3_zero_padded_filter_core_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the 3x3 filter core: drives frames, registers and backpressure, gives the verdict
module conv3x3_zero_padded_filter_core_tb;

    import c3f_pkg::*;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;
    localparam logic KSEL_BLUR = ~KSEL_SHARPEN;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int PHASE_ITEMS    = 100;
    localparam int SEND_IDLE [4]  = '{0, 85, 0, 22};
    localparam int RECV_STALL [4] = '{0, 0, 85, 22};

    typedef enum int {CUT_AND_RECONFIGURE, NOISE_BURST, OVERRUN} upset_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;

    int                   fail_count;
    int                   pending;
    logic                 frame_start;

    int                   send_idle_pct = 0;
    int                   stall_pct     = 0;
    logic                 hold_req      = 1'b0;
    int                   pixels_sent   = 0;
    int                   quiet_cycles  = 0;
    logic [DIM_W-1:0]     cur_w         = 10'd512;
    logic [DIM_W-1:0]     cur_h         = 10'd512;
    logic                 cur_k         = KSEL_SHARPEN;

    conv3x3_zero_padded_filter_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    c3f_result_checker result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .frame_start (frame_start)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready  <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int unsigned dim_in_use(input logic [DIM_W-1:0] v, input int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_KERNEL_SELECT: cur_k = val[0];
            REG_IMAGE_WIDTH:   cur_w = val;
            REG_IMAGE_HEIGHT:  cur_h = val;
            default: ;
        endcase
    endtask

    task automatic send_item(input logic act, input logic [PIX_W-1:0] pix);
        in_item_t it;
        it.action   = act;
        it.pixel_in = pix;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pixels_sent++;
    endtask

    // drain all predicted results, then let the pipeline settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // positions below w*h are picture, the rest is the drain tail
    task automatic send_frame(input int unsigned w, input int unsigned h, input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++) begin
            if (i < w * h) begin
                if ($urandom_range(0, 99) < 3) send_item(ACT_FLUSH, $urandom_range(0, 255));
                else send_item(ACT_PIXEL, rand_pixel());
            end else begin
                if ($urandom_range(0, 99) < 10) send_item(ACT_PIXEL, rand_pixel());
                else send_item(ACT_FLUSH, $urandom_range(0, 255));
            end
        end
    endtask

    task automatic send_noise(input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++) send_item($urandom_range(0, 1), $urandom_range(0, 255));
    endtask

    // flush until the stream is back at the start of a frame
    task automatic realign();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (!frame_start) begin
            send_item(ACT_FLUSH, $urandom_range(0, 255));
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic pick_size();
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        case ($urandom_range(0, 19))
            0:       w = 10'd0;
            1:       w = 10'd1;
            2, 3:    w = $urandom_range(17, 40);
            default: w = $urandom_range(2, 16);
        endcase
        case ($urandom_range(0, 19))
            0:       h = 10'd0;
            1:       h = 10'd1;
            2:       h = $urandom_range(9, 12);
            default: h = $urandom_range(2, 8);
        endcase
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    task automatic random_sequence();
        int unsigned w;
        int unsigned h;
        logic        resize;
        logic        rekernel;
        upset_t      upset;
        resize   = dim_in_use(cur_w, MAX_WIDTH_DEF) > 40 || dim_in_use(cur_h, MAX_HEIGHT) > 12 ||
                   $urandom_range(0, 1);
        rekernel = ($urandom_range(0, 9) < 3);
        if (resize || rekernel) begin
            wait_idle();
            if (resize) pick_size();
            if (rekernel) write_reg(REG_KERNEL_SELECT, {9'd0, ~cur_k});
        end
        w = dim_in_use(cur_w, MAX_WIDTH_DEF);
        h = dim_in_use(cur_h, MAX_HEIGHT);
        if ($urandom_range(0, 99) < 80) begin
            send_frame(w, h, w * h + w + 1);
        end else begin
            upset = upset_t'($urandom_range(0, 2));
            case (upset)
                CUT_AND_RECONFIGURE: begin
                    send_frame(w, h, $urandom_range(1, w * h + w));
                    wait_idle();
                    // register change with the frame cut short
                    case (cfg_reg_t'($urandom_range(0, 2)))
                        REG_KERNEL_SELECT: write_reg(REG_KERNEL_SELECT, {9'd0, ~cur_k});
                        REG_IMAGE_WIDTH:   write_reg(REG_IMAGE_WIDTH, $urandom_range(0, 16));
                        default:           write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, 8));
                    endcase
                    send_noise($urandom_range(0, 10));
                end
                NOISE_BURST: send_noise($urandom_range(5, 30));
                default:     send_frame(w, h, w * h + w + 1 + $urandom_range(1, 5));
            endcase
            realign();
        end
    endtask

    initial begin
        int i;
        int p;
        int phase_start;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // single pixel frame, zero sizes act as one
        write_reg(REG_KERNEL_SELECT, {9'd0, KSEL_SHARPEN});
        write_reg(REG_IMAGE_WIDTH, 10'd0);
        write_reg(REG_IMAGE_HEIGHT, 10'd0);
        send_item(ACT_PIXEL, 8'd255);
        send_item(ACT_FLUSH, 8'd255);
        send_item(ACT_FLUSH, 8'd0);

        // 3x3 sharpen, clamps both ways
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 10'd3);
        write_reg(REG_IMAGE_HEIGHT, 10'd3);
        for (i = 0; i < 9; i++)
            send_item(ACT_PIXEL, (i == 4) ? 8'd128 : (i % 2 == 0) ? 8'd255 : 8'd0);
        for (i = 0; i < 4; i++) send_item(ACT_FLUSH, 8'd255);

        // blur on a short row
        wait_idle();
        write_reg(REG_KERNEL_SELECT, {9'd0, KSEL_BLUR});
        write_reg(REG_IMAGE_WIDTH, 10'd2);
        write_reg(REG_IMAGE_HEIGHT, 10'd1);
        send_item(ACT_PIXEL, 8'd255);
        send_item(ACT_PIXEL, 8'd255);
        for (i = 0; i < 3; i++) send_item(ACT_FLUSH, 8'd0);

        for (p = 0; p < 4; p++) begin
            send_idle_pct = SEND_IDLE[p];
            stall_pct     = RECV_STALL[p];
            if (p == 0) begin
                // widest line, width above the maximum
                wait_idle();
                write_reg(REG_IMAGE_WIDTH, 10'd1023);
                write_reg(REG_IMAGE_HEIGHT, 10'd1);
                send_frame(MAX_WIDTH_DEF, 1, 2 * MAX_WIDTH_DEF + 1);
                // long receiver hold-off while frames keep coming
                wait_idle();
                write_reg(REG_IMAGE_WIDTH, 10'd16);
                write_reg(REG_IMAGE_HEIGHT, 10'd6);
                hold_req <= 1'b1;
                send_frame(16, 6, 16 * 6 + 17);
            end
            phase_start = pixels_sent;
            while (pixels_sent - phase_start < PHASE_ITEMS) random_sequence();
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== conv3x3_zero_padded_filter_core.f =====
sv/c3f_pkg.sv
sv/c3f_line_ram.sv
sv/c3f_ctrl.sv
sv/c3f_window.sv
sv/c3f_arith.sv
sv/conv3x3_zero_padded_filter_core.sv
test/c3f_result_checker.sv
test/conv3x3_zero_padded_filter_core_tb.sv
